// ===== src/csort_pkg.sv =====
// Shared types and constants for the counting sort engine.
// Depends on nothing; every other file in src imports it.
package csort_pkg;

  localparam int MAX_ITEMS = 64;                      // capacity of one batch
  localparam int KEY_BITS  = 8;                       // bits of a key that are sorted
  localparam int KEY_W     = 8;                       // width of the key ports
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);   // holds 0 .. MAX_ITEMS

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Contents of one cell of the sorting chain
  typedef struct packed {
    logic valid;
    key_t key;
  } cell_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic ins;     // insert key into its sorted place
    logic shift;   // move every entry one cell towards the head
    key_t key;
  } chain_cmd_t;

  // Status for the result register
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } out_stat_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } csort_state_t;

endpackage

// ===== src/counting_sort_engine.sv =====
// Counting sort engine: batch sort of unsigned keys.
// Keys enter on the in_ ports, one beat per cycle, taken when start is high and
// busy is low. in_batch_end marks the final key of a batch. Each key drops into
// its sorted place in a chain of MAX_ITEMS cells in the cycle it is taken.
// Up to MAX_ITEMS keys are kept per batch; later ones are dropped and the
// batch's results then carry out_overflowed.
// After the batch_end beat, busy rises and the sorted keys leave the head of
// the chain, one per cycle in ascending order, each on the out_ ports for one
// cycle marked by out_valid. The first result appears once the state register
// has entered drain and the output register has taken the chain head;
// out_run_end marks the last one. busy falls at the end of the last drain
// cycle, so loading of the next batch overlaps the final result. A batch is
// loaded in full before its drain begins; the drain runs at one key per cycle,
// set by the single-entry shift towards the chain head.
// Reset (rst_n low, synchronous) empties the chain and clears the count and
// overflow flag. The receiver cannot stall: every result beat is final.
// Depends on csort_pkg, csort_ctrl and csort_cell.
module counting_sort_engine
  import csort_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [KEY_W-1:0] in_key_value,
  input  logic             in_batch_end,
  output logic             out_valid,
  output logic [KEY_W-1:0] out_sorted_key,
  output logic             out_run_end,
  output logic             out_overflowed
);

  chain_cmd_t cmd;
  out_stat_t  stat;
  cell_t      cells [MAX_ITEMS];
  logic       takes [MAX_ITEMS];

  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_last_r;
  logic             out_ovf_r;

  csort_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_key_value (in_key_value),
    .in_batch_end (in_batch_end),
    .busy         (busy),
    .cmd          (cmd),
    .stat         (stat)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t left_c, right_c;
    logic  take_prev_c;

    if (i == 0) begin : g_head
      assign left_c      = '0;
      assign take_prev_c = 1'b0;
    end else begin : g_body
      assign left_c      = cells[i-1];
      assign take_prev_c = takes[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_inner
      assign right_c = cells[i+1];
    end

    csort_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left      (left_c),
      .take_prev (take_prev_c),
      .right     (right_c),
      .take      (takes[i]),
      .entry     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r  <= KEY_W'(cells[0].key);
    out_last_r <= stat.last;
    out_ovf_r  <= stat.ovf;
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_run_end    = out_last_r;
  assign out_overflowed = out_ovf_r;

  // A result beat only follows a drain cycle
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a drain cycle");

  // While draining, the chain head always holds a key
  a_head_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cells[0].valid)
    else $error("drain from an empty chain");

  // The chain stays sorted at its head
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cells[0].valid && cells[1].valid) |-> (cells[0].key <= cells[1].key))
    else $error("chain head out of order");

  // The run ends with a gap before any further result
  a_gap_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_end) |=> !out_valid)
    else $error("result beat straight after run end");

endmodule

// ===== src/csort_cell.sv =====
// One cell of the insertion chain: holds a single key, kept in ascending order.
// Depends on csort_pkg.
module csort_cell
  import csort_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_cmd_t cmd,
  input  cell_t      left,       // neighbour towards the head
  input  logic       take_prev,  // neighbour towards the head is taking the new key
  input  cell_t      right,      // neighbour towards the tail
  output logic       take,
  output cell_t      entry
);

  logic valid_r, valid_nxt;
  key_t key_r, key_nxt;

  // An empty cell counts as larger than any key; the strict compare keeps equal keys in arrival order
  assign take = !valid_r || (key_r > cmd.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    priority if (cmd.ins && take) begin
      if (take_prev) begin
        valid_nxt = left.valid;
        key_nxt   = left.key;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = cmd.key;
      end
    end else if (cmd.shift) begin
      valid_nxt = right.valid;
      key_nxt   = right.key;
    end else begin
      valid_nxt = valid_r;
      key_nxt   = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign entry.valid = valid_r;
  assign entry.key   = key_r;

endmodule

// ===== src/csort_ctrl.sv =====
// Batch controller: counts loaded keys, tracks overflow and sequences the drain.
// Depends on csort_pkg.
module csort_ctrl
  import csort_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [KEY_W-1:0] in_key_value,
  input  logic       in_batch_end,
  output logic       busy,
  output chain_cmd_t cmd,
  output out_stat_t  stat
);

  csort_state_t state_r, state_nxt;
  cnt_t         cnt_r, cnt_nxt;
  logic         ovf_r, ovf_nxt;
  logic         accept;
  logic         full;

  assign full   = (cnt_r == cnt_t'(MAX_ITEMS));
  assign accept = start && (state_r == ST_LOAD);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (accept && in_batch_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (cnt_r == cnt_t'(1))     state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Outputs and datapath counters
  always_comb begin
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    busy      = 1'b0;
    cmd.ins   = 1'b0;
    cmd.shift = 1'b0;
    cmd.key   = key_t'(in_key_value);
    stat      = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_nxt = 1'b1;   // beat dropped, batch_end still honoured
          end else begin
            cmd.ins = 1'b1;
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
      end
      ST_DRAIN: begin
        busy       = 1'b1;
        cmd.shift  = 1'b1;
        stat.valid = 1'b1;
        stat.last  = (cnt_r == cnt_t'(1));
        stat.ovf   = ovf_r;
        cnt_nxt    = cnt_r - cnt_t'(1);
        if (cnt_r == cnt_t'(1)) begin
          ovf_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ===== test/counting_sort_engine_tb.sv =====
// Self-checking bench for counting_sort_engine: batches of keys go in, and each
// sorted output beat is checked against a histogram-based sorter kept here.
// Depends on csort_pkg and the counting_sort_engine RTL.
`timescale 1ns / 1ps

module counting_sort_engine_tb;
  import csort_pkg::*;

  localparam int NUM_BINS    = 1 << KEY_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_ITEMS  = 40;   // no gaps once this few keys are left

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             drain_first;   // hold off until all sorted beats are out
  } key_beat_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic             run_end;
    logic             ovf;
  } sorted_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [KEY_W-1:0] in_key_value = '0;
  logic             in_batch_end = 1'b0;
  logic             out_valid;
  logic [KEY_W-1:0] out_sorted_key;
  logic             out_run_end;
  logic             out_overflowed;

  key_beat_t    key_queue[$];
  sorted_beat_t sorted_queue[$];
  key_beat_t    on_port;

  // sorter state
  logic [KEY_W-1:0] batch_keys[MAX_ITEMS];
  int               bin_tally[NUM_BINS];
  int               kept_count = 0;
  logic             batch_dropped = 1'b0;

  int fails = 0;
  int cycles = 0;
  int gap_left = 0;
  bit gaps_on = 1'b1;

  counting_sort_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_key_value   (in_key_value),
    .in_batch_end   (in_batch_end),
    .out_valid      (out_valid),
    .out_sorted_key (out_sorted_key),
    .out_run_end    (out_run_end),
    .out_overflowed (out_overflowed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
    fails++;
  endtask

  // Take one key into the batch; on the batch end, place stably and queue beats.
  task automatic sort_take(key_beat_t kb);
    logic [KEY_W-1:0] placed[MAX_ITEMS];
    sorted_beat_t     sb;
    key_t             k;
    int               pos;
    k = kb.key[KEY_BITS-1:0];
    if (kept_count < MAX_ITEMS) begin
      batch_keys[kept_count] = kb.key;
      bin_tally[k]++;
      kept_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (kb.last) begin
      for (int b = 1; b < NUM_BINS; b++) bin_tally[b] += bin_tally[b-1];
      for (int i = kept_count - 1; i >= 0; i--) begin
        k = batch_keys[i][KEY_BITS-1:0];
        pos = bin_tally[k];
        placed[pos-1] = KEY_W'(k);
        bin_tally[k]--;
      end
      for (int i = 0; i < kept_count; i++) begin
        sb.key     = placed[i];
        sb.run_end = (i == kept_count - 1);
        sb.ovf     = batch_dropped;
        sorted_queue.insert(sorted_queue.size(), sb);
      end
      for (int b = 0; b < NUM_BINS; b++) bin_tally[b] = 0;
      kept_count    = 0;
      batch_dropped = 1'b0;
    end
  endtask

  task automatic queue_batch(int n, bit narrow, bit drain);
    key_beat_t kb;
    for (int i = 0; i < n; i++) begin
      kb.key         = narrow ? KEY_W'($urandom_range(0, 3) * 85) : KEY_W'($urandom_range(0, 255));
      kb.last        = (i == n - 1);
      kb.drain_first = drain && (i == 0);
      key_queue.insert(key_queue.size(), kb);
    end
  endtask

  // driver
  always @(posedge clk) begin
    key_beat_t kb;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // offered beat not taken yet: hold it
    end else begin
      if (start) sort_take(on_port);
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (key_queue.size() == 0 ||
                   (key_queue[0].drain_first && sorted_queue.size() != 0)) begin
        start <= 1'b0;
      end else begin
        if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
        if (gaps_on && key_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 16) - 1;
          start <= 1'b0;
        end else begin
          kb = key_queue.pop_front();
          on_port = kb;
          start        <= 1'b1;
          in_key_value <= kb.key;
          in_batch_end <= kb.last;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_valid) begin
      if (sorted_queue.size() == 0) begin
        report_mismatch("unexpected beat, out_sorted_key", out_sorted_key, -1);
      end else begin
        want = sorted_queue.pop_front();
        if (out_sorted_key !== want.key)
          report_mismatch("out_sorted_key", out_sorted_key, want.key);
        if (out_run_end !== want.run_end)
          report_mismatch("out_run_end", out_run_end, want.run_end);
        if (out_overflowed !== want.ovf)
          report_mismatch("out_overflowed", out_overflowed, want.ovf);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    key_beat_t kb;
    int        total;
    int        n;
    logic [KEY_W-1:0] edge_keys[6] = '{8'd255, 8'd0, 8'd170, 8'd85, 8'd0, 8'd255};

    for (int b = 0; b < NUM_BINS; b++) bin_tally[b] = 0;
    kb.drain_first = 1'b0;

    // single-key batches at both ends of the key range
    kb.key = 8'd0;   kb.last = 1'b1; key_queue.insert(key_queue.size(), kb);
    kb.key = 8'd255; kb.last = 1'b1; key_queue.insert(key_queue.size(), kb);
    // extremes and duplicates; wait for the previous batch to drain first
    foreach (edge_keys[i]) begin
      kb.key         = edge_keys[i];
      kb.last        = (i == 5);
      kb.drain_first = (i == 0);
      key_queue.insert(key_queue.size(), kb);
    end
    kb.drain_first = 1'b0;
    // one-hot keys, descending, so every key bit toggles
    for (int i = 7; i >= 0; i--) begin
      kb.key  = KEY_W'(1 << i);
      kb.last = (i == 0);
      key_queue.insert(key_queue.size(), kb);
    end
    total = 16;

    // buffer full: one batch past capacity (batch end on a dropped key), one exactly full
    n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
    queue_batch(n, 1'b0, 1'b0);
    queue_batch(MAX_ITEMS, 1'b1, 1'b1);
    total += n + MAX_ITEMS;

    while (total < 300) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6)
                                       : $urandom_range(1, 16);
      queue_batch(n, $urandom_range(0, 1), $urandom_range(0, 7) == 0);
      total += n;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sample mid-cycle so the driver's and monitor's updates have settled
    @(negedge clk);
    while (key_queue.size() != 0 || start) @(negedge clk);
    while (sorted_queue.size() != 0) @(negedge clk);
    repeat (MAX_ITEMS + 10) @(posedge clk);

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
